// ===== hw/rtl/lts_pkg.sv =====
// Shared types and constants for the LRU tagged slot table.
// Holds field widths, opcode and status codes, and controller/datapath interface structs.
// No dependencies.
package lts_pkg;

    localparam int OP_W     = 3;
    localparam int MODEL_W  = 64;
    localparam int CACHE_W  = 64;
    localparam int WINDOW_W = 31;
    localparam int SIDX_W   = 3;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;
    localparam int STAMP_W  = 64;

    localparam int IN_BITS   = OP_W + MODEL_W + CACHE_W + WINDOW_W + SIDX_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + SLOT_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_FIND       = 3'd0,
        OP_CLAIM      = 3'd1,
        OP_PUBLISH    = 3'd2,
        OP_INVALIDATE = 3'd3,
        OP_DROP       = 3'd4,
        OP_RESET_ALL  = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_MISS        = 3'd0,
        STS_HIT         = 3'd1,
        STS_CLAIM_MATCH = 3'd2,
        STS_CLAIM_FREE  = 3'd3,
        STS_CLAIM_EVICT = 3'd4,
        STS_DONE        = 3'd5,
        STS_IGNORED     = 3'd6
    } status_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } lts_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic out_free;
    } lts_sts_t;

endpackage

// ===== hw/rtl/lts_ctrl.sv =====
// Controller for the LRU tagged slot table.
// Sequences accept, execute, LRU scan and commit; depends on lts_pkg.
module lts_ctrl
    import lts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  lts_sts_t sts,
    output lts_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EVICT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.needs_scan) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end else if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/lts_datapath.sv =====
// Datapath for the LRU tagged slot table: slot tags, valid bits, use stamps,
// tag compares, LRU scan and the result register. Depends on lts_pkg.
module lts_datapath
    import lts_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  lts_cmd_t              cmd,
    output lts_sts_t              sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [OP_W-1:0]     op_reg;
    logic [MODEL_W-1:0]  mtag_reg;
    logic [CACHE_W-1:0]  ctag_reg;
    logic [WINDOW_W-1:0] wtag_reg;
    logic [SIDX_W-1:0]   sidx_reg;

    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [MODEL_W-1:0]  model_reg  [SLOTS];
    logic [CACHE_W-1:0]  cache_reg  [SLOTS];
    logic [WINDOW_W-1:0] window_reg [SLOTS];
    logic [STAMP_W-1:0]  stamp_reg  [SLOTS];
    logic [STAMP_W-1:0]  counter_reg;

    logic [IdxW-1:0]     ptr_reg;
    logic [IdxW-1:0]     min_idx_reg;
    logic [STAMP_W-1:0]  min_stamp_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic [SLOTS-1:0]    match_vec, drop_vec, clear_vec;
    logic                any_match, any_free;
    logic [IdxW-1:0]     match_idx, free_idx, target_idx, sidx;
    logic                sidx_ok;
    logic                do_stamp, do_publish;
    logic [STAMP_W-1:0]  stamp_new, scan_stamp;

    assign sidx       = IdxW'(sidx_reg);
    assign sidx_ok    = ({29'd0, sidx_reg} < SLOTS);
    assign stamp_new  = counter_reg + STAMP_W'(1);
    assign scan_stamp = stamp_reg[ptr_reg];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_vec[i] = valid_reg[i] && (model_reg[i] == mtag_reg)
                           && (cache_reg[i] == ctag_reg) && (window_reg[i] == wtag_reg);
            drop_vec[i]  = valid_reg[i] && (cache_reg[i] == ctag_reg);
        end
    end

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match_vec[i]) match_idx = IdxW'(i);
            if (!valid_reg[i]) free_idx = IdxW'(i);
        end
    end

    assign any_match = |match_vec;
    assign any_free  = ~&valid_reg;

    assign sts.needs_scan = (op_reg == OP_CLAIM) && !any_match && !any_free;
    assign sts.scan_last  = (ptr_reg == IdxW'(SLOTS - 1));
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_comb begin
        out_status_next = STS_IGNORED;
        out_slot_next   = '0;
        out_count_next  = '0;
        clear_vec       = '0;
        target_idx      = sidx;
        do_stamp        = 1'b0;
        do_publish      = 1'b0;
        unique case (op_reg)
            OP_FIND: begin
                target_idx = match_idx;
                if (any_match) begin
                    do_stamp        = 1'b1;
                    out_status_next = STS_HIT;
                    out_slot_next   = SLOT_W'(match_idx);
                end else begin
                    out_status_next = STS_MISS;
                end
            end
            OP_CLAIM: begin
                if (any_match) begin
                    target_idx      = match_idx;
                    out_status_next = STS_CLAIM_MATCH;
                end else if (any_free) begin
                    target_idx      = free_idx;
                    out_status_next = STS_CLAIM_FREE;
                end else begin
                    target_idx      = min_idx_reg;
                    out_status_next = STS_CLAIM_EVICT;
                end
                do_stamp              = 1'b1;
                clear_vec[target_idx] = 1'b1;
                out_slot_next         = SLOT_W'(target_idx);
            end
            OP_PUBLISH: begin
                if (sidx_ok) begin
                    do_publish      = 1'b1;
                    out_status_next = STS_DONE;
                    out_slot_next   = SLOT_W'(sidx);
                end
            end
            OP_INVALIDATE: begin
                if (sidx_ok) begin
                    clear_vec[sidx] = 1'b1;
                    out_status_next = STS_DONE;
                    out_slot_next   = SLOT_W'(sidx);
                end
            end
            OP_DROP: begin
                if (ctag_reg != '0) begin
                    clear_vec       = drop_vec;
                    out_count_next  = COUNT_W'($countones(drop_vec));
                    out_status_next = STS_DONE;
                end
            end
            OP_RESET_ALL: begin
                clear_vec       = '1;
                out_count_next  = COUNT_W'($countones(valid_reg));
                out_status_next = STS_DONE;
            end
            default: begin
                out_status_next = STS_IGNORED;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg & ~clear_vec;
        if (do_publish) valid_next[sidx] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tdata[OP_W-1:0];
            mtag_reg <= s_tdata[OP_W +: MODEL_W];
            ctag_reg <= s_tdata[OP_W+MODEL_W +: CACHE_W];
            wtag_reg <= s_tdata[OP_W+MODEL_W+CACHE_W +: WINDOW_W];
            sidx_reg <= s_tdata[OP_W+MODEL_W+CACHE_W+WINDOW_W +: SIDX_W];
        end
        if (cmd.scan_start) begin
            ptr_reg       <= IdxW'(1);
            min_idx_reg   <= '0;
            min_stamp_reg <= stamp_reg[0];
        end else if (cmd.scan_step) begin
            ptr_reg <= ptr_reg + IdxW'(1);
            if (scan_stamp < min_stamp_reg) begin
                min_idx_reg   <= ptr_reg;
                min_stamp_reg <= scan_stamp;
            end
        end
        if (cmd.commit) begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_count_reg  <= out_count_next;
            for (int i = 0; i < SLOTS; i++) begin
                if (clear_vec[i]) begin
                    model_reg[i]  <= '0;
                    cache_reg[i]  <= '0;
                    window_reg[i] <= '0;
                end
            end
            if (do_publish) begin
                model_reg[sidx]  <= mtag_reg;
                cache_reg[sidx]  <= ctag_reg;
                window_reg[sidx] <= wtag_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cmd.commit) begin
                valid_reg <= valid_next;
                if (do_stamp) begin
                    counter_reg           <= stamp_new;
                    stamp_reg[target_idx] <= stamp_new;
                end
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                       out_count_reg, out_slot_reg, out_status_reg};

endmodule

// ===== hw/rtl/lru_tagged_slot_table_core.sv =====
// LRU tagged slot table, top level.
// Instantiates lts_ctrl and lts_datapath; depends on lts_pkg.
//
// A fully associative directory of SLOTS entries, each tagged by model, cache
// and window keys, with a valid bit and a 64-bit use stamp for LRU replacement.
// Input channel s_*: one operation per transfer (find, claim, publish,
// invalidate slot, drop by cache tag, reset all). Result channel m_*: exactly
// one result transfer per operation, in order.
// Sequence: an operation is accepted into the input registers, executes in
// the EXEC state and its result is registered once the output register is
// free, which raises m_tvalid. A claim that must evict first walks the use
// stamps one slot per cycle in the SCAN state, then commits in the EVICT
// state. A new operation is not accepted until the previous one has
// committed; the stamp walk makes an evicting claim take longer.
// s_tready is high only while no operation is in progress; the next one is
// accepted while an earlier result still waits in the output register.
// When m_tready is low the result holds; a following operation executes and
// then waits until the output register is free.
// Reset (aresetn low, synchronous) clears all valid bits, use stamps and the
// stamp counter, and empties the output register; no clearing pass is needed.
module lru_tagged_slot_table_core
    import lts_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode, model_tag, cache_tag, window_tag, slot_index (from bit 0 up)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, slot, dropped_count (from bit 0 up)
    output logic [OUT_DATA_W-1:0] m_tdata
);

    lts_cmd_t cmd;
    lts_sts_t sts;

    lts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lts_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
